[hw/rtl/sdnc_pkg.sv]
// ----------------------------------------------------------------------------
// sdnc_pkg
// Shared types and constants of the sphere direction nearest cell quantizer.
// ----------------------------------------------------------------------------
package sdnc_pkg;

    // Fixed field widths
    localparam int IDX_W  = 5;   // entry index of a load
    localparam int CELL_W = 5;   // result cell index
    localparam int PCNT_W = 6;   // point count register

    localparam logic [PCNT_W-1:0] PCNT_RESET = 6'd32;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Classified operation, front to back
    typedef struct packed {
        logic query;   // nearest search
        logic write;   // table write with an index in range
    } t_op_ctl;

    // Back end sequencer
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

endpackage

[hw/rtl/sdnc_front.sv]
// ----------------------------------------------------------------------------
// sdnc_front
// Accepts input items, classifies them and drops loads with an index past the
// table.
// ----------------------------------------------------------------------------
module sdnc_front import sdnc_pkg::*; #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_cmd,
    input  logic [IDX_W-1:0]              i_entry_index,
    input  logic signed [COORD_BITS-1:0]  i_vec_x,
    input  logic signed [COORD_BITS-1:0]  i_vec_y,
    input  logic signed [COORD_BITS-1:0]  i_vec_z,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output t_op_ctl                       o_op_ctl,
    output logic [IDX_W-1:0]              o_op_addr,
    output logic [3*COORD_BITS-1:0]       o_op_vec
);

    logic accept;
    logic in_range;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign in_range = int'(i_entry_index) < MAX_POINTS;

    always_comb begin
        o_op_ctl.query = (i_cmd == CMD_QUERY);
        o_op_ctl.write = (i_cmd == CMD_LOAD) && in_range;
    end

    // Drop loads that fall outside the table
    assign o_q_push  = accept && (o_op_ctl.query || o_op_ctl.write);
    assign o_op_addr = i_entry_index;
    assign o_op_vec  = {i_vec_x, i_vec_y, i_vec_z};

endmodule

[hw/rtl/sdnc_queue.sv]
// ----------------------------------------------------------------------------
// sdnc_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module sdnc_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

endmodule

[hw/rtl/sdnc_back.sv]
// ----------------------------------------------------------------------------
// sdnc_back
// Point table, dot product pipeline and nearest search sequencer.
// ----------------------------------------------------------------------------
module sdnc_back import sdnc_pkg::*; #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [PCNT_W-1:0]         i_cfg_wdata,
    input  logic                      i_q_empty,
    output logic                      o_q_pop,
    input  t_op_ctl                   i_op_ctl,
    input  logic [IDX_W-1:0]          i_op_addr,
    input  logic [3*COORD_BITS-1:0]   i_op_vec,
    output logic                      o_res_valid,
    input  logic                      i_res_take,
    output logic [CELL_W-1:0]         o_nearest_cell
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CB = COORD_BITS;
    localparam int VW = 3 * CB;
    localparam int PW = 2 * CB;
    localparam int DW = 2 * CB + 1;

    logic [VW-1:0]         r_table [MAX_POINTS];
    t_state                r_state;
    t_state                n_state;
    logic [PCNT_W-1:0]     r_point_count;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         r_last_idx;
    logic [AW-1:0]         n_last_idx;
    logic signed [CB-1:0]  r_qx;
    logic signed [CB-1:0]  r_qy;
    logic signed [CB-1:0]  r_qz;
    logic [VW-1:0]         r_rdata;
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    logic                  r_last1;
    logic                  r_last2;
    logic                  r_last3;
    logic                  r_first1;
    logic                  r_first2;
    logic                  r_first3;
    logic [AW-1:0]         r_idx1;
    logic [AW-1:0]         r_idx2;
    logic [AW-1:0]         r_idx3;
    logic signed [PW-1:0]  r_px;
    logic signed [PW-1:0]  r_py;
    logic signed [PW-1:0]  r_pz;
    logic signed [DW-1:0]  r_dot;
    logic signed [DW-1:0]  r_best;
    logic [AW-1:0]         r_best_idx;
    logic                  r_out_valid;
    logic [AW-1:0]         r_out;

    logic                  take_out;
    logic                  start_query;
    logic                  pop_load;
    logic                  wr_en;
    logic                  rd_en;
    logic                  update;
    logic                  finish;
    logic [AW-1:0]         win_idx;
    logic [AW-1:0]         wr_addr;

    assign take_out = i_res_take && r_out_valid;

    // Start a query only when the result register is free by its end
    always_comb begin
        start_query = 1'b0;
        pop_load    = 1'b0;
        if (r_state == S_IDLE && !i_q_empty) begin
            if (i_op_ctl.query) begin
                start_query = !r_out_valid || take_out;
            end else begin
                pop_load = 1'b1;
            end
        end
    end

    assign o_q_pop = start_query || pop_load;
    assign wr_en   = pop_load && i_op_ctl.write;
    assign wr_addr = AW'(i_op_addr);
    assign rd_en   = (r_state == S_SCAN);

    // Clamp the count to one through the table size
    always_comb begin
        priority if (r_point_count == '0) begin
            n_last_idx = '0;
        end else if (int'(r_point_count) >= MAX_POINTS) begin
            n_last_idx = AW'(MAX_POINTS - 1);
        end else begin
            n_last_idx = AW'(r_point_count - 1'b1);
        end
    end

    assign update  = r_v3 && (r_first3 || (r_dot > r_best));
    assign win_idx = update ? r_idx3 : r_best_idx;
    assign finish  = r_v3 && r_last3;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start_query) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == r_last_idx) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= PCNT_RESET;
            r_addr        <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_wdata;
            end
            if (start_query) begin
                r_addr <= '0;
            end else if (rd_en) begin
                r_addr <= r_addr + 1'b1;
            end
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (take_out) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= i_op_vec;
        end
        if (rd_en) begin
            r_rdata <= r_table[r_addr];
        end
    end

    // Dot product pipeline: read, multiply, sum, compare
    always_ff @(posedge i_clk) begin
        if (start_query) begin
            r_qx       <= $signed(i_op_vec[VW-1:2*CB]);
            r_qy       <= $signed(i_op_vec[2*CB-1:CB]);
            r_qz       <= $signed(i_op_vec[CB-1:0]);
            r_last_idx <= n_last_idx;
        end
        r_idx1   <= r_addr;
        r_last1  <= (r_addr == r_last_idx);
        r_first1 <= (r_addr == '0);

        r_px     <= r_qx * $signed(r_rdata[VW-1:2*CB]);
        r_py     <= r_qy * $signed(r_rdata[2*CB-1:CB]);
        r_pz     <= r_qz * $signed(r_rdata[CB-1:0]);
        r_idx2   <= r_idx1;
        r_last2  <= r_last1;
        r_first2 <= r_first1;

        r_dot    <= DW'(r_px) + DW'(r_py) + DW'(r_pz);
        r_idx3   <= r_idx2;
        r_last3  <= r_last2;
        r_first3 <= r_first2;

        if (update) begin
            r_best <= r_dot;
        end
        if (r_v3) begin
            r_best_idx <= win_idx;
        end
        if (finish) begin
            r_out <= win_idx;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_nearest_cell = CELL_W'(r_out);

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE))
        else $error("operation taken while a query runs");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_last_idx))
        else $error("scan address past last entry");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> !r_out_valid)
        else $error("query finished over a waiting result");

endmodule

[hw/rtl/sphere_direction_nearest_cell_top.sv]
// ----------------------------------------------------------------------------
// sphere_direction_nearest_cell_top
// Nearest direction quantizer on the unit sphere over a loadable point table.
// ----------------------------------------------------------------------------
// A load (cmd 0) writes one Q1.14 direction into the point table and returns
// nothing; a load whose index is past the table is dropped. A query (cmd 1)
// returns the index of the table point with the largest exact dot product
// against the query vector, lowest index on ties, which for unit table points
// is the nearest point on the sphere. Only entries 0 to point_count-1 take
// part (a count of zero acts as one, a count past the table as the full
// table), and every one of them must have been loaded. Both sides look like
// queues: items enter through push/full into a four-deep queue, results leave
// through empty/pop from an output register. While a result waits, loads still
// pass; full rises once a waiting query and the items behind it fill the queue.
// A query scans the table, which has one read port and delivers one entry per
// cycle into a read, multiply, sum, compare pipeline; the back end takes no
// other item until the scan ends. A query starts only once the previous result
// has been taken or is being taken. The user must write point_count through
// i_cfg_we/i_cfg_wdata only while the block is idle (not enforced); it resets to 32.
// ----------------------------------------------------------------------------
module sphere_direction_nearest_cell_top import sdnc_pkg::*; #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration
    input  logic                          i_cfg_we,
    input  logic [PCNT_W-1:0]             i_cfg_wdata,
    // Input items
    input  logic                          push,
    output logic                          full,
    input  logic                          i_cmd,
    input  logic [IDX_W-1:0]              i_entry_index,
    input  logic signed [COORD_BITS-1:0]  i_vec_x,
    input  logic signed [COORD_BITS-1:0]  i_vec_y,
    input  logic signed [COORD_BITS-1:0]  i_vec_z,
    // Results
    output logic                          empty,
    input  logic                          pop,
    output logic [CELL_W-1:0]             o_nearest_cell
);

    localparam int CTL_W = $bits(t_op_ctl);
    localparam int VW    = 3 * COORD_BITS;
    localparam int QW    = CTL_W + IDX_W + VW;

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    logic [QW-1:0]     q_wdata;
    logic [QW-1:0]     q_rdata;
    t_op_ctl           f_ctl;
    logic [IDX_W-1:0]  f_addr;
    logic [VW-1:0]     f_vec;
    t_op_ctl           b_ctl;
    logic [IDX_W-1:0]  b_addr;
    logic [VW-1:0]     b_vec;
    logic              res_valid;

    // Front: classify and drop out-of-range loads
    sdnc_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_push        (push),
        .o_full        (full),
        .i_cmd         (i_cmd),
        .i_entry_index (i_entry_index),
        .i_vec_x       (i_vec_x),
        .i_vec_y       (i_vec_y),
        .i_vec_z       (i_vec_z),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_op_ctl      (f_ctl),
        .o_op_addr     (f_addr),
        .o_op_vec      (f_vec)
    );

    assign q_wdata = {f_ctl, f_addr, f_vec};

    // Hold classified operations until the back end is free
    sdnc_queue #(
        .W     (QW),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign b_ctl  = t_op_ctl'(q_rdata[QW-1:IDX_W+VW]);
    assign b_addr = q_rdata[IDX_W+VW-1:VW];
    assign b_vec  = q_rdata[VW-1:0];

    // Back: table writes and the nearest search
    sdnc_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_op_ctl       (b_ctl),
        .i_op_addr      (b_addr),
        .i_op_vec       (b_vec),
        .o_res_valid    (res_valid),
        .i_res_take     (pop),
        .o_nearest_cell (o_nearest_cell)
    );

    assign empty = !res_valid;

endmodule
